>>> rtl/core/bhp_pkg.sv
package bhp_pkg;

  localparam int LOG_FRACTION_BITS_DEF = 16;
  localparam int PRESS_W = 24;
  localparam int TEMP_W = 12;
  localparam int HEIGHT_W = 23;
  localparam int EXP_W = 5;
  localparam int TSUM_W = 16;
  localparam int MANT_W = 31;
  localparam int T_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUND_PRESSURE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUND_TEMPERATURE = 2'd1;

  localparam logic [PRESS_W-1:0] GROUND_PRESSURE_RST = 24'd10240000;
  localparam logic [TEMP_W-1:0] GROUND_TEMPERATURE_RST = 12'd240;

  localparam logic [31:0] HK_Q30 = 32'd2178143819;
  localparam logic signed [17:0] KELVIN_SUM_80 = 18'sd43704;
  localparam logic [HEIGHT_W-1:0] FAULT_HEIGHT = 23'd533328;
  localparam logic [HEIGHT_W:0] HEIGHT_MAX = 24'd4194303;
  localparam logic [HEIGHT_W:0] HEIGHT_MIN_MAG = 24'd4194304;

  typedef struct packed {
    logic valid;
    logic fault;
    logic [TSUM_W-1:0] tsum;
    logic [EXP_W-1:0] exp_g;
    logic [EXP_W-1:0] exp_p;
  } bhp_side_t;

  // Position of the leading one; zero for zero.
  function automatic logic [EXP_W-1:0] lead_one(input logic [PRESS_W-1:0] x);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int i = 0; i < PRESS_W; i++) begin
      if (x[i]) e = EXP_W'(i);
    end
    return e;
  endfunction

endpackage

>>> rtl/core/bhp_log_cell.sv
module bhp_log_cell #(
  parameter int F = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  bhp_pkg::bhp_side_t       side_i,
  input  logic [bhp_pkg::MANT_W-1:0] m_g_i,
  input  logic [bhp_pkg::MANT_W-1:0] m_p_i,
  input  logic [F-1:0]             frac_g_i,
  input  logic [F-1:0]             frac_p_i,
  output bhp_pkg::bhp_side_t       side_o,
  output logic [bhp_pkg::MANT_W-1:0] m_g_o,
  output logic [bhp_pkg::MANT_W-1:0] m_p_o,
  output logic [F-1:0]             frac_g_o,
  output logic [F-1:0]             frac_p_o
);
  import bhp_pkg::*;

  logic [2*MANT_W-1:0] sq_g, sq_p;
  logic [MANT_W:0]     q_g, q_p;
  logic                bit_g, bit_p;
  logic [MANT_W-1:0]   m_g_nxt, m_p_nxt;
  bhp_side_t           side_r;
  logic [MANT_W-1:0]   m_g_r, m_p_r;
  logic [F-1:0]        frac_g_r, frac_p_r;

  // Square, truncate back to Q1.30, renormalize on overflow past 2.0.
  assign sq_g = m_g_i * m_g_i;
  assign sq_p = m_p_i * m_p_i;
  assign q_g = sq_g[MANT_W+30:30];
  assign q_p = sq_p[MANT_W+30:30];
  assign bit_g = q_g[MANT_W];
  assign bit_p = q_p[MANT_W];
  assign m_g_nxt = bit_g ? q_g[MANT_W:1] : q_g[MANT_W-1:0];
  assign m_p_nxt = bit_p ? q_p[MANT_W:1] : q_p[MANT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
      m_g_r <= m_g_nxt;
      m_p_r <= m_p_nxt;
      frac_g_r <= {frac_g_i[F-2:0], bit_g};
      frac_p_r <= {frac_p_i[F-2:0], bit_p};
    end
  end

  assign side_o = side_r;
  assign m_g_o = m_g_r;
  assign m_p_o = m_p_r;
  assign frac_g_o = frac_g_r;
  assign frac_p_o = frac_p_r;

endmodule

>>> rtl/core/bhp_post.sv
module bhp_post #(
  parameter int F = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  bhp_pkg::bhp_side_t                 side_i,
  input  logic [F-1:0]                       frac_g_i,
  input  logic [F-1:0]                       frac_p_i,
  output logic                               valid_o,
  output logic signed [bhp_pkg::HEIGHT_W-1:0] height_o,
  output logic                               fault_o
);
  import bhp_pkg::*;

  localparam int MAG_W = EXP_W + F;
  localparam int PROD_W = T_W + MAG_W;
  localparam int SH = 14 + F;
  localparam int RND_W = PROD_W + 1 - SH;

  // Stage 1: temperature scale and log difference.
  logic [TSUM_W+31:0] tk_full;
  logic [MAG_W-1:0]   lg, lp;
  logic               v1_r, f1_r, n1_r;
  logic [T_W-1:0]     t1_r;
  logic [MAG_W-1:0]   mag1_r;

  assign tk_full = side_i.tsum * HK_Q30;
  assign lg = {side_i.exp_g, frac_g_i};
  assign lp = {side_i.exp_p, frac_p_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= side_i.valid;
      f1_r <= side_i.fault;
      n1_r <= lp > lg;
      t1_r <= tk_full[T_W+15:16];
      mag1_r <= (lp > lg) ? (lp - lg) : (lg - lp);
    end
  end

  // Stage 2: product.
  logic            v2_r, f2_r, n2_r;
  logic [PROD_W-1:0] prod2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
      f2_r <= f1_r;
      n2_r <= n1_r;
      prod2_r <= PROD_W'(t1_r) * PROD_W'(mag1_r);
    end
  end

  // Stage 3: round half away, saturate, sign.
  logic [PROD_W:0]     rsum;
  logic [RND_W-1:0]    rnd;
  logic [HEIGHT_W:0]   rsat;
  logic [HEIGHT_W:0]   hneg;
  logic [HEIGHT_W-1:0] h_nxt;
  logic                v3_r, f3_r;
  logic [HEIGHT_W-1:0] h3_r;

  assign rsum = {1'b0, prod2_r} + ((PROD_W+1)'(1) << (13 + F));
  assign rnd = rsum[PROD_W:SH];

  always_comb begin
    if (n2_r) begin
      rsat = (rnd > RND_W'(HEIGHT_MIN_MAG)) ? HEIGHT_MIN_MAG : rnd[HEIGHT_W:0];
    end else begin
      rsat = (rnd > RND_W'(HEIGHT_MAX)) ? HEIGHT_MAX : rnd[HEIGHT_W:0];
    end
    hneg = -rsat;
    if (f2_r) begin
      h_nxt = FAULT_HEIGHT;
    end else if (n2_r) begin
      h_nxt = hneg[HEIGHT_W-1:0];
    end else begin
      h_nxt = rsat[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
      f3_r <= f2_r;
      h3_r <= h_nxt;
    end
  end

  assign valid_o = v3_r;
  assign fault_o = f3_r;
  assign height_o = h3_r;

endmodule

>>> rtl/core/barometric_height_from_pressure_core.sv
// Throughput: one beat per cycle while the output is not stalled; the log2 is a chain
// of LOG_FRACTION_BITS squaring cells, each cell one fraction bit, followed by three
// arithmetic stages.
// The whole pipe advances together whenever the output register is free or taken.
// Reset (rst_n, synchronous, low) clears all valid flags and loads the ground
// registers with their calibration defaults.
module barometric_height_from_pressure_core #(
  parameter int LOG_FRACTION_BITS = bhp_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bhp_pkg::PRESS_W-1:0]          in_pressure_sample,
  input  logic signed [bhp_pkg::TEMP_W-1:0]    in_temperature_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bhp_pkg::HEIGHT_W-1:0]  out_height,
  output logic                                 out_sensor_fault,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bhp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bhp_pkg::PRESS_W-1:0]          cfg_data
);
  import bhp_pkg::*;

  localparam int F = LOG_FRACTION_BITS;

  logic [PRESS_W-1:0] ground_pressure_r;
  logic [TEMP_W-1:0]  ground_temperature_r;
  logic               en;

  // Config writes are always taken; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_pressure_r <= GROUND_PRESSURE_RST;
      ground_temperature_r <= GROUND_TEMPERATURE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GROUND_PRESSURE:    ground_pressure_r <= cfg_data;
        CFG_GROUND_TEMPERATURE: ground_temperature_r <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipe when the result register is empty or being drained.
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Front stage: normalize both pressures to Q1.30, form the kelvin sum.
  logic [PRESS_W-1:0]     pg;
  logic [EXP_W-1:0]       eg, ep;
  logic [MANT_W-1:0]      mg, mp;
  logic signed [17:0]     tsum_w;
  bhp_side_t              side_nxt;

  always_comb begin
    pg = (ground_pressure_r == '0) ? PRESS_W'(1) : ground_pressure_r;
    eg = lead_one(pg);
    ep = lead_one(in_pressure_sample);
    mg = MANT_W'(pg) << (5'd30 - eg);
    mp = MANT_W'(in_pressure_sample) << (5'd30 - ep);
    tsum_w = 18'sd5 * (18'(signed'(ground_temperature_r)) + 18'(in_temperature_sample))
             + KELVIN_SUM_80;
    side_nxt.valid = in_valid;
    side_nxt.fault = (in_pressure_sample == '0);
    side_nxt.tsum = tsum_w[TSUM_W-1:0];
    side_nxt.exp_g = eg;
    side_nxt.exp_p = ep;
  end

  bhp_side_t          side_c [0:F];
  logic [MANT_W-1:0]  mg_c   [0:F];
  logic [MANT_W-1:0]  mp_c   [0:F];
  logic [F-1:0]       fg_c   [0:F];
  logic [F-1:0]       fp_c   [0:F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_c[0].valid <= 1'b0;
    end else if (en) begin
      side_c[0] <= side_nxt;
      mg_c[0] <= mg;
      mp_c[0] <= mp;
    end
  end

  assign fg_c[0] = '0;
  assign fp_c[0] = '0;

  // Chain of squaring cells, one fraction bit per cell.
  for (genvar k = 0; k < F; k++) begin : g_cell
    bhp_log_cell #(.F(F)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .side_i   (side_c[k]),
      .m_g_i    (mg_c[k]),
      .m_p_i    (mp_c[k]),
      .frac_g_i (fg_c[k]),
      .frac_p_i (fp_c[k]),
      .side_o   (side_c[k+1]),
      .m_g_o    (mg_c[k+1]),
      .m_p_o    (mp_c[k+1]),
      .frac_g_o (fg_c[k+1]),
      .frac_p_o (fp_c[k+1])
    );
  end

  // Scale, multiply, round and saturate; last stage is the output register.
  bhp_post #(.F(F)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side_i   (side_c[F]),
    .frac_g_i (fg_c[F]),
    .frac_p_i (fp_c[F]),
    .valid_o  (out_valid),
    .height_o (out_height),
    .fault_o  (out_sensor_fault)
  );

endmodule

>>> bench/barometric_height_from_pressure_core_tb.sv
module barometric_height_from_pressure_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bhp_pkg::*;

  localparam int FRAC = LOG_FRACTION_BITS_DEF;
  // Pipe depth is FRAC + 4; drain a bit longer than that.
  localparam int DRAIN_CYCLES = FRAC + 12;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 300;
  localparam int ITEMS_PER_PHASE = 280;
  // Indexes past the two registers: the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [HEIGHT_W-1:0] FAULT_ALT = 23'd533328;

  // Predicts heights from the calibration registers and holds them in order.
  class height_scoreboard;
    logic [PRESS_W-1:0] ground_p;
    logic signed [TEMP_W-1:0] ground_t;
    logic [HEIGHT_W-1:0] exp_height[$];
    logic exp_fault[$];
    int errors;

    function new();
      ground_p = GROUND_PRESSURE_RST;
      ground_t = GROUND_TEMPERATURE_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PRESS_W-1:0] data);
      if (idx == CFG_GROUND_PRESSURE) ground_p = data;
      else if (idx == CFG_GROUND_TEMPERATURE) ground_t = data[TEMP_W-1:0];
    endfunction

    // Integer part is the leading-one position; fraction bits by repeated squaring.
    function longint unsigned log2q(logic [PRESS_W-1:0] x);
      longint unsigned mant, frac;
      int e;
      e = 0;
      frac = 0;
      for (int i = 0; i < PRESS_W; i++) if (x[i]) e = i;
      mant = 64'(x) << (30 - e);
      for (int i = 0; i < FRAC; i++) begin
        mant = (mant * mant) >> 30;
        frac = frac << 1;
        if (mant >= (64'd1 << 31)) begin
          frac = frac | 1;
          mant = mant >> 1;
        end
      end
      return (64'(e) << FRAC) | frac;
    endfunction

    function void note_sample(logic [PRESS_W-1:0] p, logic signed [TEMP_W-1:0] ts);
      logic [PRESS_W-1:0] pg;
      longint unsigned tq, lg, lp, mag, rnd;
      int tsum;
      bit neg;
      logic [HEIGHT_W-1:0] h;
      if (p == 0) begin
        exp_height.push_back(FAULT_ALT);
        exp_fault.push_back(1'b1);
        return;
      end
      pg = (ground_p == 0) ? 24'd1 : ground_p;
      tsum = 5 * (int'(ground_t) + int'(ts)) + 43704;
      tq = (64'(tsum) * 64'd2178143819) >> 16;
      lg = log2q(pg);
      lp = log2q(p);
      neg = lp > lg;
      mag = neg ? lp - lg : lg - lp;
      rnd = (tq * mag + (64'd1 << (13 + FRAC))) >> (14 + FRAC);
      if (neg) begin
        if (rnd > 64'd4194304) rnd = 64'd4194304;
        h = HEIGHT_W'(-rnd);
      end else begin
        if (rnd > 64'd4194303) rnd = 64'd4194303;
        h = HEIGHT_W'(rnd);
      end
      exp_height.push_back(h);
      exp_fault.push_back(1'b0);
    endfunction

    function void check_height(logic [HEIGHT_W-1:0] h, logic f);
      logic [HEIGHT_W-1:0] eh;
      logic ef;
      if (exp_height.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: height %0d fault %0b",
                                   $signed(h), f);
        return;
      end
      eh = exp_height.pop_front();
      ef = exp_fault.pop_front();
      if (h !== eh || f !== ef) begin
        errors++;
        if (errors <= 10)
          $display("height mismatch: exp %0d/%0b got %0d/%0b",
                   $signed(eh), ef, $signed(h), f);
      end
    endfunction

    function int pending();
      return exp_height.size();
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [PRESS_W-1:0] in_pressure_sample;
  logic signed [TEMP_W-1:0] in_temperature_sample;
  logic out_valid, out_ready;
  logic signed [HEIGHT_W-1:0] out_height;
  logic out_sensor_fault;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PRESS_W-1:0] cfg_data;

  height_scoreboard sb;
  bit long_hold_req = 0;
  bit steady_rx = 0;
  int idle_cycles = 0;

  barometric_height_from_pressure_core uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Monitor: every beat is sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_sample(in_pressure_sample, in_temperature_sample);
      if (out_valid && out_ready) sb.check_height(out_height, out_sensor_fault);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random ready runs and stalls, plus one long hold on request.
  initial begin
    int run, stall;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        @(negedge clk) out_ready <= 0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 0;
      end
      run = $urandom_range(1, 20);
      repeat (run) @(negedge clk) out_ready <= 1;
      if (!steady_rx) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
        repeat (stall) @(negedge clk) out_ready <= 0;
      end
    end
  end

  // Offer one sample; hold valid and payload until the beat goes through.
  task automatic send_sample(logic [PRESS_W-1:0] p, logic signed [TEMP_W-1:0] t,
                             bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(10, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    repeat (gap) @(negedge clk) in_valid <= 0;
    @(negedge clk);
    in_valid <= 1;
    in_pressure_sample <= p;
    in_temperature_sample <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drop_valid();
    @(negedge clk) in_valid <= 0;
  endtask

  // Wait until every expected height is in, then give the pipe time to empty.
  task automatic drain();
    drop_valid();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [PRESS_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 0;
  endtask

  function automatic logic signed [TEMP_W-1:0] rand_temp();
    return TEMP_W'(int'($urandom_range(0, 3327)) - 1280);
  endfunction

  // Half near-ground pressures, plus the full range, zero, equal, powers of two and small values.
  function automatic logic [PRESS_W-1:0] rand_press(logic [PRESS_W-1:0] gp);
    int sel;
    longint v;
    sel = $urandom_range(0, 19);
    if (sel < 10) begin
      v = longint'(gp) + longint'($urandom_range(0, 131072)) - 65536;
      if (v < 1) v = 1;
      if (v > 16777215) v = 16777215;
      return PRESS_W'(v);
    end
    if (sel < 16) return PRESS_W'($urandom);
    if (sel == 16) return '0;
    if (sel == 17) return gp;
    if (sel == 18) return PRESS_W'(1) << $urandom_range(0, 23);
    return PRESS_W'($urandom_range(1, 255));
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++)
      send_sample(rand_press(sb.ground_p), rand_temp(), 1'b1);
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_pressure_sample = '0;
    in_temperature_sample = '0;
    cfg_valid = 0;
    cfg_index = CFG_GROUND_PRESSURE;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed beats at reset calibration: extremes, fault, equal pressure.
    send_sample('0, 12'sd0, 1'b0);
    send_sample(24'd1, -12'sd1280, 1'b0);
    send_sample(24'hFFFFFF, 12'sd2047, 1'b0);
    send_sample(GROUND_PRESSURE_RST, 12'sd240, 1'b0);
    send_sample(GROUND_PRESSURE_RST, -12'sd1280, 1'b0);
    send_sample(24'd10239999, 12'sd2047, 1'b0);
    send_sample(24'd10240001, 12'sd0, 1'b0);
    send_sample(24'h800000, 12'sd100, 1'b0);
    send_sample(24'h7FFFFF, -12'sd100, 1'b0);
    send_sample('0, 12'sd2047, 1'b0);
    drain();

    // Extreme calibration: lowest ground pressure and coldest ground.
    write_cfg(CFG_GROUND_PRESSURE, 24'd1);
    write_cfg(CFG_GROUND_TEMPERATURE, 24'(-12'sd1280));
    send_sample(24'd1, 12'sd0, 1'b0);
    send_sample(24'hFFFFFF, 12'sd2047, 1'b0);
    send_sample(24'hFFFFFF, -12'sd1280, 1'b0);
    send_sample(24'd2, 12'sd5, 1'b0);
    random_items(ITEMS_PER_PHASE);
    drain();

    // Hottest ground, highest pressure; hold the receiver off so the pipe fills.
    write_cfg(CFG_GROUND_PRESSURE, 24'hFFFFFF);
    write_cfg(CFG_GROUND_TEMPERATURE, 24'(12'sd2047));
    send_sample(24'd1, 12'sd2047, 1'b0);
    send_sample(24'd1, -12'sd1280, 1'b0);
    send_sample(24'hFFFFFF, 12'sd2047, 1'b0);
    long_hold_req = 1;
    random_items(ITEMS_PER_PHASE);
    drain();

    // Ground pressure of zero behaves as one; spare indexes must not disturb it.
    write_cfg(CFG_GROUND_PRESSURE, '0);
    write_cfg(CFG_SPARE_A, 24'h123456);
    write_cfg(CFG_SPARE_B, 24'hFFFFFF);
    send_sample(24'd1, 12'sd0, 1'b0);
    send_sample(24'd3, 12'sd0, 1'b0);
    random_items(ITEMS_PER_PHASE / 2);
    drain();

    // Random calibrations, one stretch without receiver stalls.
    for (int k = 0; k < 3; k++) begin
      write_cfg(CFG_GROUND_PRESSURE, PRESS_W'($urandom_range(1, 16777215)));
      write_cfg(CFG_GROUND_TEMPERATURE, 24'(rand_temp()));
      steady_rx = (k == 1);
      random_items(ITEMS_PER_PHASE);
      drain();
    end
    steady_rx = 0;

    // Back to typical calibration for the tail.
    write_cfg(CFG_GROUND_PRESSURE, GROUND_PRESSURE_RST);
    write_cfg(CFG_GROUND_TEMPERATURE, 24'(GROUND_TEMPERATURE_RST));
    random_items(ITEMS_PER_PHASE / 2);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
